>>> sv/fct_pkg.sv
// Shared types and constants for the frustum containment test core.
`default_nettype none

package fct_pkg;

  localparam int unsigned PlaneCount = 6;
  localparam int unsigned AxisCount  = 3;
  localparam int unsigned PlaneIdxW  = $clog2(PlaneCount);
  localparam int unsigned CoordW     = 16;
  localparam int unsigned RadiusW    = 15;
  localparam int unsigned PlaneW     = 64;
  // Q1.14 x Q8.8 gives Q.22; offset and radius are aligned by this shift
  localparam int unsigned FracAlign  = 14;
  localparam int unsigned ProdW      = 2 * CoordW;
  // three products plus aligned offset, never overflows
  localparam int unsigned DistW      = ProdW + 2;

  typedef enum logic [1:0] {
    FnPoint  = 2'd0,
    FnSphere = 2'd1,
    FnBox    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CtDisjoint     = 2'd0,
    CtContained    = 2'd1,
    CtIntersecting = 2'd2
  } contain_e;

  // packed plane register layout
  typedef struct packed {
    logic signed [CoordW-1:0] off;
    logic signed [CoordW-1:0] nz;
    logic signed [CoordW-1:0] ny;
    logic signed [CoordW-1:0] nx;
  } plane_t;

endpackage

`default_nettype wire

>>> sv/frustum_containment_test_core.sv
// Frustum containment test core: plane registers and the three-stage classify pipe.
`default_nettype none

// Classifies a point, sphere or axis-aligned box against six planes held in
// configuration registers 0..5 (top, bottom, left, right, near, far). One item
// is taken every clock cycle (busy_o stays low); its result is strobed on
// result_valid_o after passing three registers in order: the input register,
// a register after the 36 parallel 16x16 normal-by-coordinate multipliers,
// and the result register after the distance sums and compares. The receiver
// cannot stall, so each result is shown for exactly one cycle. The user must
// write planes only while no item is in flight; the block does not enforce
// this. The config port is always ready.
module frustum_containment_test_core (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  output logic                             busy_o,
  input  wire        [1:0]                 func_i,
  input  wire signed [fct_pkg::CoordW-1:0] pos_x_i,
  input  wire signed [fct_pkg::CoordW-1:0] pos_y_i,
  input  wire signed [fct_pkg::CoordW-1:0] pos_z_i,
  input  wire        [fct_pkg::RadiusW-1:0] radius_i,
  input  wire signed [fct_pkg::CoordW-1:0] max_x_i,
  input  wire signed [fct_pkg::CoordW-1:0] max_y_i,
  input  wire signed [fct_pkg::CoordW-1:0] max_z_i,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire        [2:0]                 cfg_index_i,
  input  wire        [fct_pkg::PlaneW-1:0] cfg_data_i,
  output logic                             result_valid_o,
  output logic       [1:0]                 containment_o,
  output logic                             touches_o
);
  import fct_pkg::*;

  plane_t plane_q [PlaneCount];

  // stage 0: input register
  logic                      v0_q;
  logic [1:0]                func0_q;
  logic [RadiusW-1:0]        rad0_q;
  logic signed [CoordW-1:0]  pos0_q [AxisCount];
  logic signed [CoordW-1:0]  max0_q [AxisCount];

  // stage 1: product register
  logic                      v1_q;
  logic [1:0]                func1_q;
  logic [RadiusW-1:0]        rad1_q;
  logic signed [ProdW-1:0]   pp_d [PlaneCount][AxisCount];
  logic signed [ProdW-1:0]   pm_d [PlaneCount][AxisCount];
  logic signed [ProdW-1:0]   pp_q [PlaneCount][AxisCount];
  logic signed [ProdW-1:0]   pm_q [PlaneCount][AxisCount];

  // stage 2: result register
  logic                      v2_q;
  logic [1:0]                cont_d, cont_q;

  logic signed [CoordW-1:0]  nrm [PlaneCount][AxisCount];
  logic signed [DistW-1:0]   dist_p [PlaneCount];
  logic signed [DistW-1:0]   dist_hi [PlaneCount];
  logic signed [DistW-1:0]   dist_lo [PlaneCount];
  logic signed [DistW-1:0]   rad_pos, rad_neg;
  logic [PlaneCount-1:0]     pt_out, sp_out, sp_cut, bx_out, bx_in;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // plane registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PlaneCount; k++) begin
        plane_q[k] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o &&
                 ({1'b0, cfg_index_i} < (PlaneIdxW + 1)'(PlaneCount))) begin
      plane_q[cfg_index_i[PlaneIdxW-1:0]] <= plane_t'(cfg_data_i);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start_i && !busy_o;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func0_q   <= func_i;
      rad0_q    <= radius_i;
      pos0_q[0] <= pos_x_i;
      pos0_q[1] <= pos_y_i;
      pos0_q[2] <= pos_z_i;
      max0_q[0] <= max_x_i;
      max0_q[1] <= max_y_i;
      max0_q[2] <= max_z_i;
    end
    func1_q <= func0_q;
    rad1_q  <= rad0_q;
    pp_q    <= pp_d;
    pm_q    <= pm_d;
    cont_q  <= cont_d;
  end

  // one multiplier per plane, axis and corner coordinate
  always_comb begin
    for (int k = 0; k < PlaneCount; k++) begin
      nrm[k][0] = plane_q[k].nx;
      nrm[k][1] = plane_q[k].ny;
      nrm[k][2] = plane_q[k].nz;
      for (int a = 0; a < AxisCount; a++) begin
        pp_d[k][a] = nrm[k][a] * pos0_q[a];
        pm_d[k][a] = nrm[k][a] * max0_q[a];
      end
    end
  end

  // Per plane: center distance, and the farthest and nearest box corners
  // (per axis pick the larger or smaller product). All corners are on the
  // positive side iff the nearest is; none is iff the farthest is not.
  always_comb begin
    rad_pos = DistW'({rad1_q, FracAlign'(0)});
    rad_neg = -rad_pos;
    for (int k = 0; k < PlaneCount; k++) begin
      dist_p[k]  = DistW'(plane_q[k].off) <<< FracAlign;
      dist_hi[k] = DistW'(plane_q[k].off) <<< FracAlign;
      dist_lo[k] = DistW'(plane_q[k].off) <<< FracAlign;
      for (int a = 0; a < AxisCount; a++) begin
        dist_p[k] = dist_p[k] + DistW'(pp_q[k][a]);
        if (pp_q[k][a] > pm_q[k][a]) begin
          dist_hi[k] = dist_hi[k] + DistW'(pp_q[k][a]);
          dist_lo[k] = dist_lo[k] + DistW'(pm_q[k][a]);
        end else begin
          dist_hi[k] = dist_hi[k] + DistW'(pm_q[k][a]);
          dist_lo[k] = dist_lo[k] + DistW'(pp_q[k][a]);
        end
      end
      pt_out[k] = dist_p[k] < 0;
      sp_out[k] = dist_p[k] <= rad_neg;
      sp_cut[k] = dist_p[k] <= rad_pos;
      bx_out[k] = dist_hi[k] < 0;
      bx_in[k]  = dist_lo[k] >= 0;
    end
  end

  always_comb begin
    case (func1_q)
      FnPoint: begin
        cont_d = (|pt_out) ? CtDisjoint : CtContained;
      end
      FnSphere: begin
        if (|sp_out) cont_d = CtDisjoint;
        else if (|sp_cut) cont_d = CtIntersecting;
        else cont_d = CtContained;
      end
      FnBox: begin
        if (|bx_out) cont_d = CtDisjoint;
        else if (&bx_in) cont_d = CtContained;
        else cont_d = CtIntersecting;
      end
      default: begin
        cont_d = CtDisjoint;
      end
    endcase
  end

  assign result_valid_o = v2_q;
  assign containment_o  = cont_q;
  assign touches_o      = (cont_q != CtDisjoint);

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 result_valid_o)
    else $error("result strobe missing three cycles after start transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(v0_q, 2))
    else $error("result strobe without an accepted item");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (containment_o == CtDisjoint || containment_o == CtContained ||
                        containment_o == CtIntersecting))
    else $error("containment code out of range");

  a_unused_func: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && func1_q == 2'd3 |=> containment_o == CtDisjoint && !touches_o)
    else $error("unused shape code must classify as disjoint");

  a_box_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && func1_q == FnBox && (|bx_out) |=> containment_o == CtDisjoint)
    else $error("box wholly outside a plane not reported disjoint");
`endif

endmodule

`default_nettype wire
